// File: rtl/msf_pkg.sv
// ----------------------------------------------------------------------------
// msf_pkg
// Shared command codes, status codes and field widths for the message slot
// FIFO.
// ----------------------------------------------------------------------------
package msf_pkg;

    // Fixed widths of the transaction fields
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned SLOT_IN_W = 4;
    localparam int unsigned OFS_IN_W = 6;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned STAT_W   = 3;
    localparam int unsigned HANDLE_W = 4;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned BYTES_W  = 7;

    // Handle shown when no slot applies
    localparam logic signed [HANDLE_W-1:0] NO_SLOT = -4'sd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_COMMIT  = 2'd1,
        CMD_READ    = 2'd2,
        CMD_RELEASE = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_BAD_SLOT = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    // Memory access enables from the controller
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

// File: rtl/msf_store.sv
// ----------------------------------------------------------------------------
// msf_store
// Byte store for all message slots: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module msf_store import msf_pkg::*; #(
    parameter int unsigned DEPTH  = 512,
    parameter int unsigned ADDR_W = 9
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_ctl,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write the appended byte
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Register the read byte
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/msf_ctrl.sv
// ----------------------------------------------------------------------------
// msf_ctrl
// Slot ring control: head and tail pointers, ready count and running byte
// index. Checks handles, builds store addresses and registers the status.
// ----------------------------------------------------------------------------
module msf_ctrl import msf_pkg::*; #(
    parameter int unsigned SLOT_COUNT = 8,
    parameter int unsigned SLOT_BYTES = 64,
    parameter int unsigned ADDR_W     = 9
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  t_cmd                        i_cmd,
    input  logic [SLOT_IN_W-1:0]        i_slot,
    input  logic [OFS_IN_W-1:0]         i_offset,
    output t_mem_ctl                    o_mem_ctl,
    output logic [ADDR_W-1:0]           o_wr_addr,
    output logic [ADDR_W-1:0]           o_rd_addr,
    output logic                        o_valid,
    output logic                        o_rd_ok,
    output t_status                     o_status,
    output logic signed [HANDLE_W-1:0]  o_free_slot,
    output logic signed [HANDLE_W-1:0]  o_ready_slot,
    output logic [COUNT_W-1:0]          o_ready_count,
    output logic [BYTES_W-1:0]          o_bytes_written
);

    localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
    localparam int unsigned CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int unsigned IDX_W  = $clog2(SLOT_BYTES + 1);
    localparam int unsigned OFS_W  = $clog2(SLOT_BYTES);

    localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0]      CNT_FULL  = CNT_W'(SLOT_COUNT);
    localparam logic [IDX_W-1:0]      IDX_FULL  = IDX_W'(SLOT_BYTES);
    localparam logic [SLOT_IN_W:0]    SLOT_LIM  = (SLOT_IN_W + 1)'(SLOT_COUNT);
    localparam logic [OFS_IN_W:0]     OFS_LIM   = (OFS_IN_W + 1)'(SLOT_BYTES);
    localparam logic [ADDR_W-1:0]     SLOT_SPAN = ADDR_W'(SLOT_BYTES);

    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0]  r_ready, n_ready;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_valid;
    logic              r_rd_ok, n_rd_ok;
    t_status           r_status, n_status;

    logic              slot_ok;
    logic              ofs_ok;
    logic [ADDR_W-1:0] slot_base;

    // Check handles and form the slot base address
    assign slot_ok   = {1'b0, i_slot} < SLOT_LIM;
    assign ofs_ok    = {1'b0, i_offset} < OFS_LIM;
    assign slot_base = ADDR_W'(i_slot[SLOT_W-1:0]) * SLOT_SPAN;
    assign o_wr_addr = slot_base + ADDR_W'(r_idx[OFS_W-1:0]);
    assign o_rd_addr = slot_base + ADDR_W'(i_offset[OFS_W-1:0]);

    // Decode the command and advance the ring
    always_comb begin
        n_head            = r_head;
        n_tail            = r_tail;
        n_ready           = r_ready;
        n_idx             = r_idx;
        n_rd_ok           = 1'b0;
        n_status          = ST_OK;
        o_mem_ctl.wr_en   = 1'b0;
        o_mem_ctl.rd_en   = 1'b0;
        unique case (i_cmd)
            CMD_WRITE: begin
                if (!slot_ok) begin
                    n_status = ST_BAD_SLOT;
                end else if (r_idx >= IDX_FULL) begin
                    n_status = ST_DROPPED;
                end else begin
                    o_mem_ctl.wr_en = i_accept;
                    n_idx           = r_idx + IDX_W'(1);
                end
            end
            CMD_COMMIT: begin
                if (r_ready >= CNT_FULL) begin
                    n_status = ST_FULL;
                end else begin
                    n_head  = (r_head == LAST_SLOT) ? '0 : r_head + SLOT_W'(1);
                    n_idx   = '0;
                    n_ready = r_ready + CNT_W'(1);
                end
            end
            CMD_READ: begin
                if (!slot_ok || !ofs_ok) begin
                    n_status = ST_BAD_SLOT;
                end else begin
                    o_mem_ctl.rd_en = i_accept;
                    n_rd_ok         = 1'b1;
                end
            end
            CMD_RELEASE: begin
                if (r_ready == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_tail  = (r_tail == LAST_SLOT) ? '0 : r_tail + SLOT_W'(1);
                    n_ready = r_ready - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Hold ring state; update on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_ready <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
            if (i_accept) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_ready <= n_ready;
                r_idx   <= n_idx;
            end
        end
    end

    // Capture the result fields of the transaction
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_status <= n_status;
            r_rd_ok  <= n_rd_ok;
        end
    end

    // Report the state after the command
    assign o_valid         = r_valid;
    assign o_rd_ok         = r_rd_ok;
    assign o_status        = r_status;
    assign o_free_slot     = (r_ready == CNT_FULL) ? NO_SLOT : HANDLE_W'(r_head);
    assign o_ready_slot    = (r_ready == '0) ? NO_SLOT : HANDLE_W'(r_tail);
    assign o_ready_count   = COUNT_W'(r_ready);
    assign o_bytes_written = BYTES_W'(r_idx);

    // Ready count never passes the slot count
    a_ready_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready <= CNT_FULL)
        else $error("ready count above slot count");

    // A dropped byte only happens with the slot filled
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status == ST_DROPPED |-> r_idx == IDX_FULL)
        else $error("byte dropped below slot size");

    // A refused release leaves nothing ready
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status == ST_EMPTY |-> r_ready == '0)
        else $error("release refused with messages ready");

    // A refused commit leaves every slot ready
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status == ST_FULL |-> r_ready == CNT_FULL)
        else $error("commit refused with a free slot");

    // A good commit clears the byte index
    a_commit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_cmd == CMD_COMMIT && r_ready < CNT_FULL |=> r_idx == '0)
        else $error("byte index not cleared on commit");

endmodule

// File: rtl/message_slot_fifo_top.sv
// ----------------------------------------------------------------------------
// message_slot_fifo_top
// Ring of message slots in one byte store: append, commit, read and release.
// o_valid rises in the cycle after start is taken, registered in the control
// block. One transaction per cycle while busy is low; each command makes at
// most one store access or one ring pointer update.
// busy is high only in reset and the cycle after; results cannot be stalled.
// Reset clears pointers, ready count and byte index; the store is not
// cleared, and a byte never written reads as an arbitrary value.
// ----------------------------------------------------------------------------
module message_slot_fifo_top import msf_pkg::*; #(
    parameter int unsigned SLOT_COUNT = 8,
    parameter int unsigned SLOT_BYTES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [CMD_W-1:0]            i_cmd,
    input  logic [SLOT_IN_W-1:0]        i_slot,
    input  logic [OFS_IN_W-1:0]         i_offset,
    input  logic [DATA_W-1:0]           i_data,
    output logic                        o_valid,
    output logic [DATA_W-1:0]           o_read_data,
    output logic [STAT_W-1:0]           o_status,
    output logic signed [HANDLE_W-1:0]  o_free_slot,
    output logic signed [HANDLE_W-1:0]  o_ready_slot,
    output logic [COUNT_W-1:0]          o_ready_count,
    output logic [BYTES_W-1:0]          o_bytes_written
);

    localparam int unsigned DEPTH  = SLOT_COUNT * SLOT_BYTES;
    localparam int unsigned ADDR_W = $clog2(DEPTH);

    logic              r_busy;
    logic              accept;
    t_mem_ctl          mem_ctl;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] mem_q;
    logic              rd_ok;
    t_status           status;

    // Hold off transactions through reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    msf_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_cmd           (t_cmd'(i_cmd)),
        .i_slot          (i_slot),
        .i_offset        (i_offset),
        .o_mem_ctl       (mem_ctl),
        .o_wr_addr       (wr_addr),
        .o_rd_addr       (rd_addr),
        .o_valid         (o_valid),
        .o_rd_ok         (rd_ok),
        .o_status        (status),
        .o_free_slot     (o_free_slot),
        .o_ready_slot    (o_ready_slot),
        .o_ready_count   (o_ready_count),
        .o_bytes_written (o_bytes_written)
    );

    msf_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (mem_q)
    );

    // Zero the read byte for anything but a good read
    assign o_read_data = rd_ok ? mem_q : '0;
    assign o_status    = status;

    // Store is never written and read in the same cycle
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("store written and read together");

    // Store is only touched by an accepted transaction
    a_access_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.wr_en || mem_ctl.rd_en |-> accept)
        else $error("store access without a transaction");

    // Every accepted transaction gives one strobe next cycle
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("missing result strobe");

endmodule
